// ----- rtl/lar_pkg.sv -----
package lar_pkg;

    // Width of the vector fed into a normalising unit (covers every cross product)
    localparam int NW       = 48;
    // Scaled magnitude width: largest magnitude lands in [2^29, 2^30)
    localparam int MW       = 30;
    localparam int MSB_POS  = 29;
    // Sum of squares and its integer root
    localparam int SQW      = 62;
    localparam int RW       = 31;
    // Quotient bits and long-division remainder width
    localparam int QW       = 15;
    localparam int DW       = 47;
    localparam int LW       = 32;
    // Pipeline depth of one normalising unit, and of a cross-product stage pair with its unit
    localparam int NORM_LAT = 6 + RW + 1 + QW + 1;
    localparam int XLAT     = NORM_LAT + 2;
    localparam int TOP_LAT  = 3 * NORM_LAT + 4;

    typedef logic signed [NW-1:0] t_wide;
    typedef logic signed [15:0]   t_res;
    typedef logic signed [31:0]   t_pos;

endpackage

// ----- rtl/lar_norm.sv -----
module lar_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lar_pkg::t_wide i_vec [0:2],
    output logic           o_valid,
    output lar_pkg::t_res  o_res [0:2]
);

    localparam int NW  = lar_pkg::NW;
    localparam int MW  = lar_pkg::MW;
    localparam int SQW = lar_pkg::SQW;
    localparam int RW  = lar_pkg::RW;
    localparam int QW  = lar_pkg::QW;
    localparam int DW  = lar_pkg::DW;
    localparam int LW  = lar_pkg::LW;
    localparam int PW  = $clog2(NW);

    // Stage 1: split into sign and magnitude
    logic          r_v1;
    logic [2:0]    r_neg1;
    logic [NW-1:0] r_mag1 [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_neg1[i] <= i_vec[i][NW-1];
            r_mag1[i] <= i_vec[i][NW-1] ? NW'(-i_vec[i]) : NW'(i_vec[i]);
        end
    end

    // Stage 2: largest magnitude
    logic          r_v2;
    logic [2:0]    r_neg2;
    logic [NW-1:0] r_mag2 [0:2];
    logic [NW-1:0] r_max2;
    logic [NW-1:0] n_max2;

    always_comb begin
        n_max2 = r_mag1[0];
        if (r_mag1[1] > n_max2) n_max2 = r_mag1[1];
        if (r_mag1[2] > n_max2) n_max2 = r_mag1[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        r_neg2 <= r_neg1;
        r_mag2 <= r_mag1;
        r_max2 <= n_max2;
    end

    // Stage 3: leading one position of the largest magnitude
    logic          r_v3;
    logic [2:0]    r_neg3;
    logic [NW-1:0] r_mag3 [0:2];
    logic [PW-1:0] r_pos3;
    logic          r_zero3;
    logic [PW-1:0] n_pos3;

    always_comb begin
        n_pos3 = '0;
        for (int b = 0; b < NW; b++) begin
            if (r_max2[b]) n_pos3 = PW'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        r_neg3  <= r_neg2;
        r_mag3  <= r_mag2;
        r_pos3  <= n_pos3;
        r_zero3 <= (r_max2 == '0);
    end

    // Stage 4: scale all magnitudes by the same power of two
    logic          r_v4;
    logic [2:0]    r_neg4;
    logic          r_zero4;
    logic [MW-1:0] r_m4 [0:2];
    logic [NW-1:0] n_sh4 [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_pos3 >= PW'(lar_pkg::MSB_POS))
                n_sh4[i] = r_mag3[i] >> (r_pos3 - PW'(lar_pkg::MSB_POS));
            else
                n_sh4[i] = r_mag3[i] << (PW'(lar_pkg::MSB_POS) - r_pos3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3;
    end

    always_ff @(posedge i_clk) begin
        r_neg4  <= r_neg3;
        r_zero4 <= r_zero3;
        for (int i = 0; i < 3; i++) r_m4[i] <= n_sh4[i][MW-1:0];
    end

    // Stage 5: squares
    logic            r_v5;
    logic [2:0]      r_neg5;
    logic            r_zero5;
    logic [MW-1:0]   r_m5 [0:2];
    logic [2*MW-1:0] r_sq5 [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else          r_v5 <= r_v4;
    end

    always_ff @(posedge i_clk) begin
        r_neg5  <= r_neg4;
        r_zero5 <= r_zero4;
        r_m5    <= r_m4;
        for (int i = 0; i < 3; i++) r_sq5[i] <= (2*MW)'(r_m4[i]) * (2*MW)'(r_m4[i]);
    end

    // Stage 6 and root stages: one root bit per stage
    logic           r_sv   [0:RW];
    logic [2:0]     r_sneg [0:RW];
    logic           r_szero[0:RW];
    logic [MW-1:0]  r_sm   [0:RW][0:2];
    logic [63:0]    r_rem  [0:RW];
    logic [RW-1:0]  r_root [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv[0] <= 1'b0;
        else          r_sv[0] <= r_v5;
    end

    always_ff @(posedge i_clk) begin
        r_sneg[0]  <= r_neg5;
        r_szero[0] <= r_zero5;
        r_sm[0]    <= r_m5;
        r_rem[0]   <= 64'(SQW'(r_sq5[0]) + SQW'(r_sq5[1]) + SQW'(r_sq5[2]));
        r_root[0]  <= '0;
    end

    for (genvar k = 0; k < RW; k++) begin : g_root
        localparam int B = RW - 1 - k;
        logic [63:0] trial;

        assign trial = (64'(r_root[k]) << (B + 1)) + (64'd1 << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[k+1] <= 1'b0;
            else          r_sv[k+1] <= r_sv[k];
        end

        always_ff @(posedge i_clk) begin
            r_sneg[k+1]  <= r_sneg[k];
            r_szero[k+1] <= r_szero[k];
            r_sm[k+1]    <= r_sm[k];
            if (r_rem[k] >= trial) begin
                r_rem[k+1]  <= r_rem[k] - trial;
                r_root[k+1] <= r_root[k] | (RW'(1) << B);
            end else begin
                r_rem[k+1]  <= r_rem[k];
                r_root[k+1] <= r_root[k];
            end
        end
    end

    // Numerator and divisor for the rounded quotient
    logic          r_dv   [0:QW];
    logic [2:0]    r_dneg [0:QW];
    logic          r_dzero[0:QW];
    logic [LW-1:0] r_den  [0:QW];
    logic [DW-1:0] r_num  [0:QW][0:2];
    logic [QW-1:0] r_quo  [0:QW][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else          r_dv[0] <= r_sv[RW];
    end

    always_ff @(posedge i_clk) begin
        r_dneg[0]  <= r_sneg[RW];
        r_dzero[0] <= r_szero[RW];
        r_den[0]   <= {r_root[RW], 1'b0};
        for (int i = 0; i < 3; i++) begin
            r_num[0][i] <= (DW'(r_sm[RW][i]) << QW) + DW'(r_root[RW]);
            r_quo[0][i] <= '0;
        end
    end

    // Long division: one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int J = QW - 1 - k;
        logic [DW-1:0] sub;

        assign sub = DW'(r_den[k]) << J;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[k+1] <= 1'b0;
            else          r_dv[k+1] <= r_dv[k];
        end

        always_ff @(posedge i_clk) begin
            r_dneg[k+1]  <= r_dneg[k];
            r_dzero[k+1] <= r_dzero[k];
            r_den[k+1]   <= r_den[k];
            for (int i = 0; i < 3; i++) begin
                if (r_num[k][i] >= sub) begin
                    r_num[k+1][i] <= r_num[k][i] - sub;
                    r_quo[k+1][i] <= r_quo[k][i] | (QW'(1) << J);
                end else begin
                    r_num[k+1][i] <= r_num[k][i];
                    r_quo[k+1][i] <= r_quo[k][i];
                end
            end
        end
    end

    // Output: apply sign; a zero vector reads as zero. A 15-bit quotient always fits.
    logic r_ov;
    lar_pkg::t_res r_out [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else          r_ov <= r_dv[QW];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (r_dzero[QW])
                r_out[i] <= '0;
            else if (r_dneg[QW][i])
                r_out[i] <= -16'(r_quo[QW][i]);
            else
                r_out[i] <= 16'(r_quo[QW][i]);
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_out;

endmodule

// ----- rtl/look_at_rotation_top.sv -----
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-----------------------------------------
// view in   | in        | start (busy is low)  | i_eye_*, i_target_*, i_up_hint_* (Q16.16)
// axes out  | out       | o_done, one cycle    | o_side_*, o_upright_*, o_back_* (Q2.14)
//
// One transaction is taken every cycle; each result passes in series through three
// normalising units, each a 31-stage root and a 15-stage divider, and through two
// cross-product stage pairs.
// Reset is synchronous and active low; it clears the valid bits only.
// busy stays low: nothing in the pipeline ever holds, and results are not held off.
module look_at_rotation_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [31:0]    i_eye_x,
    input  logic signed [31:0]    i_eye_y,
    input  logic signed [31:0]    i_eye_z,
    input  logic signed [31:0]    i_target_x,
    input  logic signed [31:0]    i_target_y,
    input  logic signed [31:0]    i_target_z,
    input  logic signed [31:0]    i_up_hint_x,
    input  logic signed [31:0]    i_up_hint_y,
    input  logic signed [31:0]    i_up_hint_z,
    output logic                  o_done,
    output logic signed [15:0]    o_side_x,
    output logic signed [15:0]    o_side_y,
    output logic signed [15:0]    o_side_z,
    output logic signed [15:0]    o_upright_x,
    output logic signed [15:0]    o_upright_y,
    output logic signed [15:0]    o_upright_z,
    output logic signed [15:0]    o_back_x,
    output logic signed [15:0]    o_back_y,
    output logic signed [15:0]    o_back_z
);

    localparam int NW   = lar_pkg::NW;
    localparam int NL   = lar_pkg::NORM_LAT;
    localparam int XL   = lar_pkg::XLAT;

    assign busy = 1'b0;

    // Back axis: eye minus target at full width
    logic signed [32:0] diff [0:2];
    lar_pkg::t_wide     vec_a [0:2];
    lar_pkg::t_res      back  [0:2];
    logic               v_a;

    assign diff[0] = 33'(i_eye_x) - 33'(i_target_x);
    assign diff[1] = 33'(i_eye_y) - 33'(i_target_y);
    assign diff[2] = 33'(i_eye_z) - 33'(i_target_z);

    always_comb begin
        for (int i = 0; i < 3; i++) vec_a[i] = NW'(diff[i]);
    end

    lar_norm u_norm_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_vec   (vec_a),
        .o_valid (v_a),
        .o_res   (back)
    );

    // Hold the up hint until the back axis is ready
    lar_pkg::t_pos r_up [0:NL-1][0:2];

    always_ff @(posedge i_clk) begin
        r_up[0][0] <= i_up_hint_x;
        r_up[0][1] <= i_up_hint_y;
        r_up[0][2] <= i_up_hint_z;
        for (int s = 1; s < NL; s++) r_up[s] <= r_up[s-1];
    end

    // Side axis: up hint cross back, products then differences
    logic                  r_v_c1, r_v_c2;
    lar_pkg::t_wide        r_pa [0:2];
    lar_pkg::t_wide        r_pb [0:2];
    lar_pkg::t_wide        r_vec_b [0:2];
    lar_pkg::t_res         side [0:2];
    logic                  v_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_c1 <= 1'b0;
            r_v_c2 <= 1'b0;
        end else begin
            r_v_c1 <= v_a;
            r_v_c2 <= r_v_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa[0] <= NW'(r_up[NL-1][1]) * NW'(back[2]);
        r_pb[0] <= NW'(r_up[NL-1][2]) * NW'(back[1]);
        r_pa[1] <= NW'(r_up[NL-1][2]) * NW'(back[0]);
        r_pb[1] <= NW'(r_up[NL-1][0]) * NW'(back[2]);
        r_pa[2] <= NW'(r_up[NL-1][0]) * NW'(back[1]);
        r_pb[2] <= NW'(r_up[NL-1][1]) * NW'(back[0]);
        for (int i = 0; i < 3; i++) r_vec_b[i] <= r_pa[i] - r_pb[i];
    end

    lar_norm u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v_c2),
        .i_vec   (r_vec_b),
        .o_valid (v_b),
        .o_res   (side)
    );

    // Carry back axis alongside: tap for the second cross, end for the output
    lar_pkg::t_res r_back_d [0:2*XL-1][0:2];

    always_ff @(posedge i_clk) begin
        r_back_d[0] <= back;
        for (int s = 1; s < 2 * XL; s++) r_back_d[s] <= r_back_d[s-1];
    end

    // Upright axis: back cross side
    logic                  r_v_d1, r_v_d2;
    logic signed [31:0]    r_qa [0:2];
    logic signed [31:0]    r_qb [0:2];
    lar_pkg::t_wide        r_vec_c [0:2];
    lar_pkg::t_res         upright [0:2];
    lar_pkg::t_res         bk [0:2];
    logic                  v_c;

    assign bk = r_back_d[XL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_d1 <= 1'b0;
            r_v_d2 <= 1'b0;
        end else begin
            r_v_d1 <= v_b;
            r_v_d2 <= r_v_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qa[0] <= 32'(bk[1]) * 32'(side[2]);
        r_qb[0] <= 32'(bk[2]) * 32'(side[1]);
        r_qa[1] <= 32'(bk[2]) * 32'(side[0]);
        r_qb[1] <= 32'(bk[0]) * 32'(side[2]);
        r_qa[2] <= 32'(bk[0]) * 32'(side[1]);
        r_qb[2] <= 32'(bk[1]) * 32'(side[0]);
        for (int i = 0; i < 3; i++) r_vec_c[i] <= NW'(r_qa[i]) - NW'(r_qb[i]);
    end

    lar_norm u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v_d2),
        .i_vec   (r_vec_c),
        .o_valid (v_c),
        .o_res   (upright)
    );

    // Hold side axis until the upright axis is ready
    lar_pkg::t_res r_side_d [0:XL-1][0:2];

    always_ff @(posedge i_clk) begin
        r_side_d[0] <= side;
        for (int s = 1; s < XL; s++) r_side_d[s] <= r_side_d[s-1];
    end

    assign o_done      = v_c;
    assign o_side_x    = r_side_d[XL-1][0];
    assign o_side_y    = r_side_d[XL-1][1];
    assign o_side_z    = r_side_d[XL-1][2];
    assign o_upright_x = upright[0];
    assign o_upright_y = upright[1];
    assign o_upright_z = upright[2];
    assign o_back_x    = r_back_d[2*XL-1][0];
    assign o_back_y    = r_back_d[2*XL-1][1];
    assign o_back_z    = r_back_d[2*XL-1][2];

    // Every result stems from a transaction that has passed through the whole pipeline
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, lar_pkg::TOP_LAT))
        else $error("result without matching transaction");

    // A zero back axis forces zero side and upright axes
    a_zero_back : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_back_x == 16'sd0 && o_back_y == 16'sd0 && o_back_z == 16'sd0)
        |-> (o_side_x == 16'sd0 && o_side_y == 16'sd0 && o_side_z == 16'sd0 &&
             o_upright_x == 16'sd0 && o_upright_y == 16'sd0 && o_upright_z == 16'sd0))
        else $error("non-zero axis from zero back axis");

    // Unit components never exceed one; checked on the x components
    a_unit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_back_x <= 16'sd16384 && o_back_x >= -16'sd16384 &&
                    o_side_x <= 16'sd16384 && o_side_x >= -16'sd16384 &&
                    o_upright_x <= 16'sd16384 && o_upright_x >= -16'sd16384))
        else $error("axis component beyond unit range");

endmodule

// ----- bench/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] eye [3];
        logic signed [31:0] tgt [3];
        logic signed [31:0] up  [3];
    } t_view;

    typedef struct {
        logic signed [15:0] side [3];
        logic signed [15:0] upr  [3];
        logic signed [15:0] back [3];
    } t_axes;

    logic i_clk, i_rst_n, start, busy, o_done;
    logic signed [31:0] i_eye_x, i_eye_y, i_eye_z, i_target_x, i_target_y, i_target_z;
    logic signed [31:0] i_up_hint_x, i_up_hint_y, i_up_hint_z;
    logic signed [15:0] o_side_x, o_side_y, o_side_z, o_upright_x, o_upright_y, o_upright_z;
    logic signed [15:0] o_back_x, o_back_y, o_back_z;

    look_at_rotation_top uut (.*);

    t_view pending_views[$];
    t_axes expected_axes[$];
    int    mismatches = 0;
    int    axes_seen = 0;
    int    idle_cycles = 0;
    bit    stim_done = 0;
    bit    in_burst = 0;
    int    burst_left = 0;

    // Integer square root, bit by bit
    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Scale to unit length in Q2.14, zero vectors pass through
    function automatic void to_unit(input longint v[3], output longint o[3]);
        longint unsigned mag[3], m, sum, len, q;
        bit neg[3];
        m = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            o = '{0, 0, 0};
            return;
        end
        while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
            m <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
        len = root64(sum);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 15) + len) / (2 * len);
            o[i] = neg[i] ? -longint'(q) : longint'(q);
            if (o[i] > 32767) o[i] = 32767;
            if (o[i] < -32768) o[i] = -32768;
        end
    endfunction

    function automatic void cross_prod(input longint a[3], input longint b[3],
                                       output longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic t_axes predict_axes(t_view vw);
        longint d[3], u[3], bk[3], raw[3], sd[3], ur[3];
        t_axes a;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(vw.eye[i]) - longint'(vw.tgt[i]);
            u[i] = vw.up[i];
        end
        to_unit(d, bk);
        cross_prod(u, bk, raw);
        to_unit(raw, sd);
        cross_prod(bk, sd, raw);
        to_unit(raw, ur);
        for (int i = 0; i < 3; i++) begin
            a.side[i] = sd[i][15:0];
            a.upr[i] = ur[i][15:0];
            a.back[i] = bk[i][15:0];
        end
        return a;
    endfunction

    // Field-by-field comparison of two sets of axes
    function automatic bit same_axes(t_axes a, t_axes b);
        for (int i = 0; i < 3; i++) begin
            if (a.side[i] !== b.side[i] || a.upr[i] !== b.upr[i] || a.back[i] !== b.back[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Append a view to the pending queue
    function automatic void add_view(t_view vw);
        pending_views = {pending_views, vw};
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 8)) - 4;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            3: return $signed($urandom_range(0, 2 ** 20)) - 2 ** 19;
            default: return $signed($urandom_range(0, 2 ** 24)) - 2 ** 23;
        endcase
    endfunction

    function automatic t_view make_view(int e, int t, int u);
        t_view vw;
        for (int i = 0; i < 3; i++) begin
            vw.eye[i] = e;
            vw.tgt[i] = t;
            vw.up[i] = u;
        end
        return vw;
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Fill the queue: directed corners then random views
    initial begin
        t_view vw;
        add_view(make_view(0, 0, 0));
        add_view(make_view(5, 5, 65536));
        add_view(make_view(32'h7fffffff, 32'h80000000, 1));
        add_view(make_view(32'h80000000, 32'h7fffffff, -1));
        add_view(make_view(65536, 0, 65536));
        add_view(make_view(-1, 0, 0));
        add_view(make_view(32'h80000000, 32'h80000000, 32'h7fffffff));
        add_view(make_view(1, 0, 32'h80000000));
        vw = make_view(0, 0, 0);
        vw.eye[2] = 65536 * 5;
        vw.up[1] = 65536;
        add_view(vw);
        vw.up[1] = 0;
        vw.up[2] = 32'h7fffffff;
        add_view(vw);
        vw.eye = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
        vw.tgt = '{32'h80000000, 32'h7fffffff, 32'h80000000};
        vw.up = '{32'h80000000, 32'h7fffffff, 32'h80000000};
        add_view(vw);
        vw.eye = '{3, -7, 1};
        vw.tgt = '{0, 0, 0};
        vw.up = '{-1, 2, 5};
        add_view(vw);
        for (int n = 0; n < 950; n++) begin
            for (int i = 0; i < 3; i++) begin
                vw.eye[i] = rand_coord();
                vw.tgt[i] = rand_coord();
                vw.up[i] = rand_coord();
            end
            if ($urandom_range(0, 19) == 0) vw.tgt = vw.eye;
            if ($urandom_range(0, 19) == 0)
                for (int i = 0; i < 3; i++) vw.up[i] = vw.eye[i] - vw.tgt[i];
            add_view(vw);
        end
    end

    initial begin
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // Drive views in bursts with random gaps
    always @(posedge i_clk) begin
        t_view vw;
        if (!i_rst_n) begin
            start <= 0;
            {i_eye_x, i_eye_y, i_eye_z, i_target_x, i_target_y, i_target_z} <= '0;
            {i_up_hint_x, i_up_hint_y, i_up_hint_z} <= '0;
        end else begin
            if (start && !busy) begin
                vw.eye = '{i_eye_x, i_eye_y, i_eye_z};
                vw.tgt = '{i_target_x, i_target_y, i_target_z};
                vw.up = '{i_up_hint_x, i_up_hint_y, i_up_hint_z};
                expected_axes = {expected_axes, predict_axes(vw)};
            end
            if (!(start && busy)) begin
                if (burst_left == 0) begin
                    if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(1, 40);
                end
                if (burst_left > 0 && pending_views.size() > 0) begin
                    vw = pending_views.pop_front();
                    burst_left--;
                    start <= 1;
                    {i_eye_x, i_eye_y, i_eye_z} <= {vw.eye[0], vw.eye[1], vw.eye[2]};
                    {i_target_x, i_target_y, i_target_z} <= {vw.tgt[0], vw.tgt[1], vw.tgt[2]};
                    {i_up_hint_x, i_up_hint_y, i_up_hint_z} <= {vw.up[0], vw.up[1], vw.up[2]};
                end else begin
                    start <= 0;
                    if (pending_views.size() == 0) stim_done = 1;
                end
            end
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_axes e, g;
        if (i_rst_n && o_done) begin
            axes_seen++;
            g.side = '{o_side_x, o_side_y, o_side_z};
            g.upr = '{o_upright_x, o_upright_y, o_upright_z};
            g.back = '{o_back_x, o_back_y, o_back_z};
            if (expected_axes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                e = expected_axes.pop_front();
                if (!same_axes(e, g)) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp side %0d %0d %0d up %0d %0d %0d back %0d %0d %0d",
                            e.side[0], e.side[1], e.side[2], e.upr[0], e.upr[1], e.upr[2],
                            e.back[0], e.back[1], e.back[2]);
                        $display("          got side %0d %0d %0d up %0d %0d %0d back %0d %0d %0d",
                            g.side[0], g.side[1], g.side[2], g.upr[0], g.upr[1], g.upr[2],
                            g.back[0], g.back[1], g.back[2]);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 20 * lar_pkg::TOP_LAT + 2000) begin
            $display("watchdog expired");
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_axes.size() == 0);
        repeat (lar_pkg::TOP_LAT + 20) @(posedge i_clk);
        $display("covered %0d views: corners, coincident eye and target, parallel up hint",
            axes_seen);
        if (mismatches == 0 && expected_axes.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb failed");
        end
        $finish;
    end
endmodule
